// ===== design/kway_posting_merge_assert.svh =====
// ----------------------------------------------------------------------------
// kway_posting_merge assertion macros
// Concurrent assertion shorthands, sampled on clk and off while in reset.
// ----------------------------------------------------------------------------
`ifndef KWAY_POSTING_MERGE_ASSERT_SVH
`define KWAY_POSTING_MERGE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define KPM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define KPM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KPM_ASSERT_IMP(name, ante, cons)
`define KPM_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ===== design/kpm_pkg.sv =====
// ----------------------------------------------------------------------------
// kpm_pkg
// Shared constants, beat and result types for the k-way posting merge.
// ----------------------------------------------------------------------------
package kpm_pkg;

  localparam int MAX_WAYS   = 8;
  localparam int HASH_BITS  = 64;
  localparam int DOC_BITS   = 32;
  localparam int POS_BITS   = 32;
  localparam int WAY_W      = $clog2(MAX_WAYS);
  localparam int LEAVES     = 1 << WAY_W;
  localparam int KEY_W      = HASH_BITS + DOC_BITS + POS_BITS;
  localparam int IN_WAY_W   = 3;
  localparam int WIU_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAYS_IN_USE  = 3'd0,
    REG_DOC_OFFSET_1 = 3'd1,
    REG_DOC_OFFSET_2 = 3'd2,
    REG_DOC_OFFSET_3 = 3'd3,
    REG_DOC_OFFSET_4 = 3'd4,
    REG_DOC_OFFSET_5 = 3'd5,
    REG_DOC_OFFSET_6 = 3'd6,
    REG_DOC_OFFSET_7 = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    KIND_POSTING = 1'b0,
    KIND_FINISH  = 1'b1
  } kind_t;

  typedef struct packed {
    logic [IN_WAY_W-1:0]  way;
    logic                 is_end;
    logic [HASH_BITS-1:0] hash;
    logic [DOC_BITS-1:0]  doc;
    logic                 ovf;
    logic [POS_BITS-1:0]  pos;
  } beat_t;

  typedef struct packed {
    logic [HASH_BITS-1:0] hash;
    logic [DOC_BITS-1:0]  doc;
    logic [POS_BITS-1:0]  pos;
    logic                 ovf;
  } head_t;

  typedef struct packed {
    kind_t                kind;
    logic [HASH_BITS-1:0] hash;
    logic [DOC_BITS-1:0]  doc;
    logic [POS_BITS-1:0]  pos;
    logic [WAY_W-1:0]     way;
    logic                 ovf;
  } result_t;

endpackage

// ===== design/kpm_in_stage.sv =====
// ----------------------------------------------------------------------------
// kpm_in_stage
// Input register: captures a beat and adds the way's document offset.
// ----------------------------------------------------------------------------
module kpm_in_stage
  import kpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [IN_WAY_W-1:0]   in_way,
  input  logic                  in_is_end,
  input  logic [63:0]           in_key_hash,
  input  logic [31:0]           in_doc_id,
  input  logic [31:0]           in_position,
  input  logic [DOC_BITS-1:0]   doc_offset [MAX_WAYS],
  input  logic                  step,
  output logic                  beat_vld,
  output beat_t                 beat
);

  logic              vld_r, vld_nxt;
  beat_t             beat_r, beat_nxt;
  logic [DOC_BITS:0] sum;
  logic              accept;

  assign in_stall = vld_r & ~step;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    sum = {1'b0, in_doc_id[DOC_BITS-1:0]} + {1'b0, doc_offset[in_way[WAY_W-1:0]]};
    beat_nxt.way    = in_way;
    beat_nxt.is_end = in_is_end;
    beat_nxt.hash   = in_key_hash[HASH_BITS-1:0];
    beat_nxt.doc    = sum[DOC_BITS-1:0];
    beat_nxt.ovf    = sum[DOC_BITS];
    beat_nxt.pos    = in_position[POS_BITS-1:0];
    vld_nxt = accept | (vld_r & ~step);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      beat_r <= beat_nxt;
    end
  end

  assign beat_vld = vld_r;
  assign beat     = beat_r;

endmodule

// ===== design/kpm_min_tree.sv =====
// ----------------------------------------------------------------------------
// kpm_min_tree
// Comparator tree picking the smallest valid head, lowest way on ties.
// ----------------------------------------------------------------------------
module kpm_min_tree
  import kpm_pkg::*;
(
  input  head_t              heads [MAX_WAYS],
  input  logic [MAX_WAYS-1:0] cand,
  output logic               any,
  output logic [WAY_W-1:0]   best
);

  logic             node_vld [2*LEAVES];
  logic [KEY_W-1:0] node_key [2*LEAVES];
  logic [WAY_W-1:0] node_idx [2*LEAVES];
  logic             take_right;

  always_comb begin
    take_right = 1'b0;
    node_vld[0] = 1'b0;
    node_key[0] = '0;
    node_idx[0] = '0;
    for (int i = 0; i < LEAVES; i++) begin
      if (i < MAX_WAYS) begin
        node_vld[LEAVES+i] = cand[i];
        node_key[LEAVES+i] = {heads[i].hash, heads[i].doc, heads[i].pos};
      end else begin
        node_vld[LEAVES+i] = 1'b0;
        node_key[LEAVES+i] = '0;
      end
      node_idx[LEAVES+i] = WAY_W'(i);
    end
    // left child is the lower way, so it wins unless the right one is strictly less
    for (int k = LEAVES - 1; k >= 1; k--) begin
      take_right = node_vld[2*k+1] &
                   (~node_vld[2*k] | (node_key[2*k+1] < node_key[2*k]));
      node_vld[k] = node_vld[2*k] | node_vld[2*k+1];
      node_key[k] = take_right ? node_key[2*k+1] : node_key[2*k];
      node_idx[k] = take_right ? node_idx[2*k+1] : node_idx[2*k];
    end
  end

  assign any  = node_vld[1];
  assign best = node_idx[1];

endmodule

// ===== design/kpm_way_heads.sv =====
// ----------------------------------------------------------------------------
// kpm_way_heads
// Per-way head registers, end flags and the emit / finish decision.
// ----------------------------------------------------------------------------
module kpm_way_heads
  import kpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  beat_t            beat,
  input  logic [WIU_W-1:0] ways_n,
  output logic             produce,
  output result_t          res
);

`include "kway_posting_merge_assert.svh"

  head_t               heads_r [MAX_WAYS];
  head_t               heads_cur [MAX_WAYS];
  logic [MAX_WAYS-1:0] hv_r, hv_nxt, ended_r, ended_nxt;
  logic [MAX_WAYS-1:0] hv_cur, ended_cur, inuse, cand, best_oh;
  logic [WAY_W-1:0]    wi, best;
  logic                hit, load, any, ready, all_end, emit, fin;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      inuse[i] = WIU_W'(i) < ways_n;
    end
    wi   = beat.way[WAY_W-1:0];
    hit  = step & ({1'b0, beat.way} < ways_n) & ~ended_r[wi];
    load = hit & ~beat.is_end & ~hv_r[wi];

    hv_cur    = hv_r;
    ended_cur = ended_r;
    for (int i = 0; i < MAX_WAYS; i++) begin
      heads_cur[i] = heads_r[i];
    end
    if (hit && beat.is_end) begin
      ended_cur[wi] = 1'b1;
    end
    // a fresh head takes part in this cycle's compare
    if (load) begin
      hv_cur[wi]         = 1'b1;
      heads_cur[wi].hash = beat.hash;
      heads_cur[wi].doc  = beat.doc;
      heads_cur[wi].pos  = beat.pos;
      heads_cur[wi].ovf  = beat.ovf;
    end
    cand = hv_cur & inuse;
  end

  kpm_min_tree u_min_tree (
    .heads (heads_cur),
    .cand  (cand),
    .any   (any),
    .best  (best)
  );

  always_comb begin
    ready   = &(hv_cur | ended_cur | ~inuse);
    all_end = &(ended_cur | ~inuse);
    emit    = ready & any;
    fin     = all_end & ~any;
    produce = step & (emit | fin);
    best_oh = '0;
    best_oh[best] = 1'b1;

    hv_nxt    = hv_r;
    ended_nxt = ended_r;
    if (step) begin
      if (emit) begin
        hv_nxt    = hv_cur & ~best_oh;
        ended_nxt = ended_cur;
      end else if (fin) begin
        hv_nxt    = '0;
        ended_nxt = '0;
      end else begin
        hv_nxt    = hv_cur;
        ended_nxt = ended_cur;
      end
    end

    if (emit) begin
      res.kind = KIND_POSTING;
      res.hash = heads_cur[best].hash;
      res.doc  = heads_cur[best].doc;
      res.pos  = heads_cur[best].pos;
      res.way  = best;
      res.ovf  = heads_cur[best].ovf;
    end else begin
      res.kind = KIND_FINISH;
      res.hash = '0;
      res.doc  = '0;
      res.pos  = '0;
      res.way  = '0;
      res.ovf  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r    <= '0;
      ended_r <= '0;
    end else begin
      hv_r    <= hv_nxt;
      ended_r <= ended_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      heads_r[wi] <= heads_cur[wi];
    end
  end

  `KPM_ASSERT_NXT(a_emit_clears_head, step && emit, !hv_r[$past(best)])
  `KPM_ASSERT_NXT(a_finish_clears_all, step && fin && !emit, hv_r == '0 && ended_r == '0)
  `KPM_ASSERT_NXT(a_idle_holds_state, !step, $stable(hv_r) && $stable(ended_r))
  `KPM_ASSERT_NXT(a_no_silent_drop, step && !emit, ($past(hv_r) & ~hv_r) == '0)

endmodule

// ===== design/kway_posting_merge.sv =====
// ----------------------------------------------------------------------------
// kway_posting_merge
// K-way merge of sorted posting streams ordered by hash, doc id, position.
// ----------------------------------------------------------------------------
// Takes one input beat per cycle and gives at most one result per beat. A beat
// is registered (with the way's document offset already added), then the head
// update and the comparator tree over all way heads run combinationally into
// the result register. The sustained rate is one beat per clock while
// out_stall stays low. The head-update plus eight-way compare path sets the
// clock period. Send beats on an ended way to drain the remaining heads one
// per beat. No clearing pass after reset; configuration writes are always
// taken (cfg_ready is tied high) and belong only to idle periods.
// ----------------------------------------------------------------------------
module kway_posting_merge
  import kpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_way,
  input  logic                  in_is_end,
  input  logic [63:0]           in_key_hash,
  input  logic [31:0]           in_doc_id,
  input  logic [31:0]           in_position,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_kind,
  output logic [63:0]           out_hash,
  output logic [31:0]           out_doc,
  output logic [31:0]           out_position,
  output logic [2:0]            out_source_way,
  output logic                  out_doc_overflow
);

  logic [WIU_W-1:0]    wiu_r;
  logic [WIU_W-1:0]    ways_n;
  logic [DOC_BITS-1:0] offs_r [MAX_WAYS];
  logic [DOC_BITS-1:0] doc_offset [MAX_WAYS];
  logic                cfg_we;
  logic                beat_vld, step, produce;
  beat_t               beat;
  result_t             res;
  logic                out_vld_r, out_vld_nxt;
  result_t             out_r;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wiu_r <= WIU_W'(2);
      for (int i = 0; i < MAX_WAYS; i++) begin
        offs_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_WAYS_IN_USE) begin
        wiu_r <= cfg_data[WIU_W-1:0];
      end else if ({1'b0, cfg_index} < (CFG_IDX_W+1)'(MAX_WAYS)) begin
        offs_r[cfg_index[WAY_W-1:0]] <= cfg_data[DOC_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (wiu_r == '0) begin
      ways_n = WIU_W'(1);
    end else if (wiu_r > WIU_W'(MAX_WAYS)) begin
      ways_n = WIU_W'(MAX_WAYS);
    end else begin
      ways_n = wiu_r;
    end
    // way 0 carries no offset
    for (int i = 0; i < MAX_WAYS; i++) begin
      doc_offset[i] = (i == 0) ? '0 : offs_r[i];
    end
  end

  // a beat moves on whenever the result slot is free or draining
  assign step = beat_vld & (~out_vld_r | ~out_stall);

  kpm_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_way      (in_way),
    .in_is_end   (in_is_end),
    .in_key_hash (in_key_hash),
    .in_doc_id   (in_doc_id),
    .in_position (in_position),
    .doc_offset  (doc_offset),
    .step        (step),
    .beat_vld    (beat_vld),
    .beat        (beat)
  );

  kpm_way_heads u_way_heads (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .beat    (beat),
    .ways_n  (ways_n),
    .produce (produce),
    .res     (res)
  );

  always_comb begin
    if (step) begin
      out_vld_nxt = produce;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && produce) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_kind         = out_r.kind;
  assign out_hash         = 64'(out_r.hash);
  assign out_doc          = 32'(out_r.doc);
  assign out_position     = 32'(out_r.pos);
  assign out_source_way   = 3'(out_r.way);
  assign out_doc_overflow = out_r.ovf;

endmodule
